>>> src/prf_pkg.sv
// Package: shared constants, types and state encoding for the primitive root finder.
`default_nettype none
package prf_pkg;
    localparam int DEF_VALUE_WIDTH = 31;
    localparam int DEF_MAX_FACTORS = 9;
    localparam int ROOT_WIDTH      = 32;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SQ_CHECK,
        ST_STRIP_START,
        ST_STRIP_WAIT,
        ST_LEFTOVER,
        ST_CAND,
        ST_EXP_START,
        ST_EXP_WAIT,
        ST_POW_START,
        ST_POW_WAIT,
        ST_POW_CHECK,
        ST_DONE
    } prf_state_t;

    // Control bundle from the sequencer to the arithmetic units.
    typedef struct packed {
        logic start;
    } prf_go_t;
endpackage
`default_nettype wire

>>> src/prf_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module prf_divider
    import prf_pkg::*;
#(
    parameter int W = DEF_VALUE_WIDTH
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire prf_go_t      go,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              busy,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [W:0]    trial;

    // One shift-subtract step per cycle.
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[W-1]};
        if (go.start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

>>> src/prf_modmul.sv
// Bit-serial modular multiplier: (a * b) mod m, one bit of b per cycle.
`default_nettype none
module prf_modmul
    import prf_pkg::*;
#(
    parameter int W = DEF_VALUE_WIDTH
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire prf_go_t      go,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    input  wire logic [W-1:0] m,
    output logic              busy,
    output logic [W-1:0]      product
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  m_reg, m_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [W:0]    dbl;
    logic [W-1:0]  dbl_red;
    logic [W:0]    add;

    // Horner step from the top bit of b: acc = 2*acc (+ a), reduced each time.
    always_comb begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        dbl       = {acc_reg, 1'b0};
        dbl_red   = (dbl >= {1'b0, m_reg}) ? W'(dbl - {1'b0, m_reg}) : dbl[W-1:0];
        add       = {1'b0, dbl_red} + {1'b0, a_reg};
        if (go.start) begin
            acc_next  = '0;
            a_next    = a;
            b_next    = b;
            m_next    = m;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (b_reg[W-1]) begin
                acc_next = (add >= {1'b0, m_reg}) ? W'(add - {1'b0, m_reg}) : add[W-1:0];
            end else begin
                acc_next = dbl_red;
            end
            b_next   = {b_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    assign busy    = busy_reg;
    assign product = acc_reg;
endmodule
`default_nettype wire

>>> src/primitive_root_finder.sv
// Top level: sequencer that factors p-1 and tests candidates for a primitive root.
// A modulus below two reaches the result in the next cycle; otherwise each division or modular
// product runs bit-serially, trial division runs up to sqrt(p-1) divisors and each candidate
// costs a division and up to 2*VALUE_WIDTH products per prime factor.
// Throughput: one request at a time; s_ready returns the cycle after the result is taken.
// Reset (aresetn, synchronous, active low) returns the sequencer to idle, no result held.
`default_nettype none
module primitive_root_finder
    import prf_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int MAX_FACTORS = DEF_MAX_FACTORS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [VALUE_WIDTH-1:0] s_modulus,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic signed [ROOT_WIDTH-1:0] m_root
);
    localparam int W  = VALUE_WIDTH;
    localparam int FW = $clog2(MAX_FACTORS + 1);
    localparam int IW = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
    localparam int EW = $clog2(W + 1);

    prf_state_t state_reg, state_next;

    logic [W-1:0]  p_reg, p_next;
    logic [W-1:0]  phi_reg, phi_next;
    logic [W-1:0]  n_reg, n_next;
    logic [W-1:0]  d_reg, d_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  e_reg, e_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  sqr_reg, sqr_next;
    logic [EW-1:0] bit_reg, bit_next;
    logic          sq_phase_reg, sq_phase_next;
    logic          found_reg, found_next;
    logic [FW-1:0] fcnt_reg, fcnt_next;
    logic [FW-1:0] k_reg, k_next;
    logic [ROOT_WIDTH-1:0] root_reg, root_next;
    logic          stored_reg, stored_next;

    // Factor store, written and read in clocked blocks.
    logic [W-1:0] fmem [MAX_FACTORS];
    logic [W-1:0] fq_reg;
    logic         fwe;
    logic [IW-1:0] fwa;
    logic [W-1:0] fwd;

    always_ff @(posedge aclk) begin
        if (fwe) begin
            fmem[fwa] <= fwd;
        end
        fq_reg <= fmem[k_next[IW-1:0]];
    end

    // Shared divider and multiplier.
    prf_go_t      div_go, mul_go;
    logic [W-1:0] div_a, div_b, div_q, div_r;
    logic         div_busy;
    logic [W-1:0] mul_a, mul_b, mul_p;
    logic         mul_busy;

    prf_divider #(.W(W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .go(div_go), .dividend(div_a),
        .divisor(div_b), .busy(div_busy), .quotient(div_q), .remainder(div_r)
    );

    prf_modmul #(.W(W)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .go(mul_go), .a(mul_a), .b(mul_b),
        .m(p_reg), .busy(mul_busy), .product(mul_p)
    );

    // d*d <= n check by one full-width product.
    logic [2*W-1:0] dsq;
    assign dsq = d_reg * d_reg;

    // Next state and datapath.
    always_comb begin
        state_next    = state_reg;
        p_next        = p_reg;
        phi_next      = phi_reg;
        n_next        = n_reg;
        d_next        = d_reg;
        r_next        = r_reg;
        e_next        = e_reg;
        acc_next      = acc_reg;
        sqr_next      = sqr_reg;
        bit_next      = bit_reg;
        sq_phase_next = sq_phase_reg;
        found_next    = found_reg;
        fcnt_next     = fcnt_reg;
        k_next        = k_reg;
        root_next     = root_reg;
        stored_next   = stored_reg;
        fwe           = 1'b0;
        fwa           = fcnt_reg[IW-1:0];
        fwd           = d_reg;
        div_go.start  = 1'b0;
        mul_go.start  = 1'b0;
        div_a         = n_reg;
        div_b         = d_reg;
        mul_a         = acc_reg;
        mul_b         = acc_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    p_next    = s_modulus;
                    phi_next  = s_modulus - 1'b1;
                    n_next    = s_modulus - 1'b1;
                    d_next    = W'(2);
                    fcnt_next = '0;
                    root_next = '1;
                    r_next    = W'(2);
                    if (s_modulus < W'(2)) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SQ_CHECK;
                    end
                end
            end
            ST_SQ_CHECK: begin
                if (dsq <= {{W{1'b0}}, n_reg}) begin
                    stored_next = 1'b0;
                    state_next  = ST_DIV_START;
                end else begin
                    state_next = ST_LEFTOVER;
                end
            end
            ST_DIV_START: begin
                div_go.start = 1'b1;
                state_next   = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!div_busy) begin
                    if (div_r == '0) begin
                        n_next = div_q;
                        if (!stored_reg) begin
                            stored_next = 1'b1;
                            if (fcnt_reg < FW'(MAX_FACTORS)) begin
                                fwe       = 1'b1;
                                fcnt_next = fcnt_reg + 1'b1;
                            end
                        end
                        state_next = ST_DIV_START;
                    end else begin
                        d_next     = d_reg + 1'b1;
                        state_next = ST_SQ_CHECK;
                    end
                end
            end
            ST_LEFTOVER: begin
                if (n_reg > W'(1) && fcnt_reg < FW'(MAX_FACTORS)) begin
                    fwe       = 1'b1;
                    fwd       = n_reg;
                    fcnt_next = fcnt_reg + 1'b1;
                end
                state_next = ST_CAND;
            end
            ST_CAND: begin
                k_next     = '0;
                found_next = 1'b1;
                if (r_reg > p_reg || r_reg < W'(2)) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_EXP_START;
                end
            end
            ST_EXP_START: begin
                // Exponent phi / q for the current factor.
                if (k_reg >= fcnt_reg) begin
                    if (found_reg) begin
                        root_next  = ROOT_WIDTH'(r_reg);
                        state_next = ST_DONE;
                    end else begin
                        r_next     = r_reg + 1'b1;
                        state_next = ST_CAND;
                        if (r_reg == p_reg) begin
                            state_next = ST_DONE;
                        end
                    end
                end else begin
                    div_a        = phi_reg;
                    div_b        = fq_reg;
                    div_go.start = 1'b1;
                    state_next   = ST_EXP_WAIT;
                end
            end
            ST_EXP_WAIT: begin
                if (!div_busy) begin
                    e_next        = div_q;
                    acc_next      = (p_reg == W'(1)) ? '0 : W'(1);
                    sqr_next      = r_reg;
                    if (r_reg == p_reg) begin
                        sqr_next = '0;
                    end
                    bit_next      = EW'(W);
                    sq_phase_next = 1'b0;
                    state_next    = ST_POW_START;
                end
            end
            ST_POW_START: begin
                if (bit_reg == '0) begin
                    state_next = ST_POW_CHECK;
                end else if (!sq_phase_reg && e_reg[0]) begin
                    mul_a        = acc_reg;
                    mul_b        = sqr_reg;
                    mul_go.start = 1'b1;
                    state_next   = ST_POW_WAIT;
                end else if (!sq_phase_reg) begin
                    sq_phase_next = 1'b1;
                end else begin
                    mul_a        = sqr_reg;
                    mul_b        = sqr_reg;
                    mul_go.start = 1'b1;
                    state_next   = ST_POW_WAIT;
                end
            end
            ST_POW_WAIT: begin
                if (!mul_busy) begin
                    state_next = ST_POW_START;
                    if (!sq_phase_reg) begin
                        acc_next      = mul_p;
                        sq_phase_next = 1'b1;
                    end else begin
                        sqr_next      = mul_p;
                        e_next        = e_reg >> 1;
                        bit_next      = bit_reg - 1'b1;
                        sq_phase_next = 1'b0;
                        if ((e_reg >> 1) == '0) begin
                            bit_next = '0;
                        end
                    end
                end
            end
            ST_POW_CHECK: begin
                if (acc_reg == W'(1) || fq_reg == '0) begin
                    found_next = 1'b0;
                    k_next     = fcnt_reg;
                end else begin
                    k_next = k_reg + 1'b1;
                end
                state_next = ST_EXP_START;
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs.
    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        m_valid = (state_reg == ST_DONE);
    end
    assign m_root = root_reg;

    always_ff @(posedge aclk) begin
        p_reg        <= p_next;
        phi_reg      <= phi_next;
        n_reg        <= n_next;
        d_reg        <= d_next;
        r_reg        <= r_next;
        e_reg        <= e_next;
        acc_reg      <= acc_next;
        sqr_reg      <= sqr_next;
        bit_reg      <= bit_next;
        sq_phase_reg <= sq_phase_next;
        found_reg    <= found_next;
        k_reg        <= k_next;
        root_reg     <= root_next;
        stored_reg   <= stored_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fcnt_reg  <= fcnt_next;
        end
    end
endmodule
`default_nettype wire

>>> src/prf_checker.sv
// Port-level checker for the primitive root finder, bound to the top level.
`default_nettype none
module prf_props
    import prf_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    s_valid,
    input wire logic                    s_ready,
    input wire logic [VALUE_WIDTH-1:0]  s_modulus,
    input wire logic                    m_valid,
    input wire logic                    m_ready,
    input wire logic [ROOT_WIDTH-1:0]   m_root
);
    // One request at a time: no input taken while a result waits.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input ready while result pending");

    // A held result keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_root)) else $error("result dropped");

    // A modulus below two yields -1 on the next cycle.
    a_small: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_modulus < 2 |=> m_valid && m_root == '1)
        else $error("small modulus result wrong");

    // After a result is taken the block is ready again.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> s_ready) else $error("not ready after result");
endmodule

bind primitive_root_finder prf_props #(.VALUE_WIDTH(VALUE_WIDTH)) u_prf_props (.*);
`default_nettype wire

>>> verif/prf_checker.sv
// Checker for the primitive root finder: predicts each root and compares the results.
`timescale 1ns / 1ps
`default_nettype none
module prf_checker
    import prf_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int MAX_FACTORS = DEF_MAX_FACTORS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    input  wire logic                    s_ready,
    input  wire logic [VALUE_WIDTH-1:0]  s_modulus,
    input  wire logic                    m_valid,
    input  wire logic                    m_ready,
    input  wire logic [ROOT_WIDTH-1:0]   m_root,
    output int                           fail_count,
    output int                           roots_pending,
    output int                           roots_seen
);
    logic [ROOT_WIDTH-1:0] root_queue[$];
    logic [VALUE_WIDTH-1:0] modulus_queue[$];

    // Square-and-multiply with 64-bit products.
    function automatic longint unsigned pow_mod(longint unsigned base,
                                                longint unsigned expo,
                                                longint unsigned m);
        longint unsigned acc;
        longint unsigned b;
        acc = 1 % m;
        b = base % m;
        while (expo != 0) begin
            if (expo[0]) begin
                acc = (acc * b) % m;
            end
            b = (b * b) % m;
            expo = expo >> 1;
        end
        return acc;
    endfunction

    // Smallest candidate r in 2..p with r^((p-1)/q) != 1 for every stored factor q.
    function automatic logic [ROOT_WIDTH-1:0] smallest_root(logic [VALUE_WIDTH-1:0] modulus);
        longint unsigned p;
        longint unsigned phi;
        longint unsigned n;
        longint unsigned d;
        longint unsigned r;
        longint unsigned factors[MAX_FACTORS];
        int count;
        bit ok;
        p = modulus;
        count = 0;
        if (p < 2) begin
            return '1;
        end
        phi = p - 1;
        n = phi;
        for (d = 2; d * d <= n; d++) begin
            if (n % d == 0) begin
                if (count < MAX_FACTORS) begin
                    factors[count] = d;
                    count++;
                end
                while (n % d == 0) begin
                    n = n / d;
                end
            end
        end
        if (n > 1 && count < MAX_FACTORS) begin
            factors[count] = n;
            count++;
        end
        for (r = 2; r <= p; r++) begin
            ok = 1'b1;
            for (int k = 0; k < count && ok; k++) begin
                if (factors[k] == 0 || pow_mod(r, phi / factors[k], p) == 1) begin
                    ok = 1'b0;
                end
            end
            if (ok) begin
                return ROOT_WIDTH'(r);
            end
        end
        return '1;
    endfunction

    // Predict on each accepted request and compare on each accepted result.
    always @(posedge aclk) begin
        if (!aresetn) begin
            fail_count    <= 0;
            roots_seen    <= 0;
            roots_pending <= 0;
        end else begin
            roots_pending <= roots_pending + ((s_valid && s_ready) ? 1 : 0)
                             - ((m_valid && m_ready) ? 1 : 0);
            if (s_valid && s_ready) begin
                root_queue = {root_queue, smallest_root(s_modulus)};
                modulus_queue = {modulus_queue, s_modulus};
            end
            if (m_valid && m_ready) begin
                roots_seen <= roots_seen + 1;
                if (root_queue.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("Unexpected result: root %0d", $signed(m_root));
                    end
                    fail_count <= fail_count + 1;
                end else begin
                    if (m_root !== root_queue[0]) begin
                        if (fail_count < 10) begin
                            $display("Mismatch for modulus %0d: expected %0d, got %0d",
                                     modulus_queue[0], $signed(root_queue[0]),
                                     $signed(m_root));
                        end
                        fail_count <= fail_count + 1;
                    end
                    void'(root_queue.pop_front());
                    void'(modulus_queue.pop_front());
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Testbench top: drives moduli into the primitive root finder and gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_top
    import prf_pkg::*;
();

    localparam int VW          = DEF_VALUE_WIDTH;
    localparam int N_RANDOM    = 76;
    localparam int QUIET_TAIL  = 20;
    localparam int CYCLE_LIMIT = 60000000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [VW-1:0]         s_modulus;
    logic                  m_valid;
    logic                  m_ready;
    logic [ROOT_WIDTH-1:0] m_root;
    int                    fail_count;
    int                    roots_pending;
    int                    roots_seen;
    int                    cycle_count;
    bit                    quiet;
    bit                    hold_off;
    int                    sent;

    // Primes with smooth p-1, so that large moduli stay quick to factor.
    logic [VW-1:0] big_primes[5] = '{31'd2147483647, 31'd65537, 31'd998244353,
                                      31'd167772161, 31'd469762049};
    logic [VW-1:0] directed[24] = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd7,
                                    31'd8, 31'd9, 31'd6, 31'd12, 31'd15, 31'd25,
                                    31'd91, 31'd97, 31'd100, 31'd128, 31'd255, 31'd256,
                                    31'd2147483647, 31'd65537, 31'd998244353,
                                    31'd167772161, 31'd469762049};

    primitive_root_finder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_modulus(s_modulus),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_root   (m_root)
    );

    prf_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_modulus    (s_modulus),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_root       (m_root),
        .fail_count   (fail_count),
        .roots_pending(roots_pending),
        .roots_seen   (roots_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Offer one request and wait until it is taken.
    task automatic send_request(logic [VW-1:0] modulus);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            repeat (gap) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_modulus <= modulus;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid <= 1'b0;
        sent++;
    endtask

    // Result side: random bursts of back-pressure, plus one long hold-off.
    initial begin
        int burst;
        burst = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                burst = $urandom_range(0, 13);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off, counted in cycles.
    initial begin
        hold_off = 1'b0;
        wait (sent == 30);
        hold_off = 1'b1;
        repeat (3000) @(posedge aclk);
        hold_off = 1'b0;
    end

    // Stimulus and verdict.
    initial begin
        logic [VW-1:0] modulus;
        quiet     = 1'b0;
        sent      = 0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_modulus = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed[i]) begin
            send_request(directed[i]);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - QUIET_TAIL) begin
                quiet = 1'b1;
            end
            // Sender pause until the block has drained.
            if (i == N_RANDOM / 2) begin
                wait (roots_pending == 0);
            end
            if ($urandom_range(0, 19) == 0) begin
                modulus = big_primes[$urandom_range(0, 4)];
            end else begin
                modulus = VW'($urandom_range(0, 128));
            end
            send_request(modulus);
        end

        wait (roots_pending == 0);
        repeat (200) @(posedge aclk);

        $display("Run covered %0d moduli: edge values, small primes and composites,",
                 sent);
        $display("large primes up to the full width, and %0d roots checked.", roots_seen);
        if (fail_count == 0 && roots_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
src/prf_pkg.sv
src/prf_divider.sv
src/prf_modmul.sv
src/primitive_root_finder.sv
src/prf_checker.sv
verif/prf_checker.sv
verif/tb_top.sv
